/* design/rgt_pkg.sv */
// Shared types and constants for the received range gap tracker.
// Holds the request/response payload structs and operation/status codes.
// No dependencies.
package rgt_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam logic [4:0] RESULT_CAP = 5'd17;
   localparam logic [4:0] MAX_GAPS_RESET = 5'd17;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_GAPS   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_ADD   = 2'd1,
      STATUS_BAD_QUERY = 2'd2,
      STATUS_EMPTY_RM  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] item_offset;
      logic [31:0] item_length;
      logic [31:0] file_total;
      logic [31:0] query_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        gap_valid;
      logic [31:0] gap_offset;
      logic [31:0] gap_length;
      logic        last;
      logic [4:0]  entry_count;
      logic        first_valid;
      logic [31:0] first_offset;
      logic [31:0] first_length;
   } rsp_type;

endpackage

/* design/received_range_gap_tracker_unit.sv */
// Received range gap tracker: sorted range table with merge, trim and gap query.
// Top level; uses rgt_pkg and rgt_rsp_reg.
//
// Usage:
//   A request is taken on req_valid while req_stall is low. req_stall stays
//   high from acceptance until the request's last response is loaded into the
//   output register; one request is worked on at a time.
//   Each request gives one response, a gap query up to max_gaps responses;
//   the final one carries last. Responses leave through a one-deep output
//   register on rsp_valid/rsp_stall; a stalled response holds and the
//   sequencer waits for the register to free.
//   csr_write_enable writes max_gaps (values above 17 act as 17).
// Sequencing:
//   Clear and bad requests go from dispatch to the finish state; remove trims the
//   first range in place or shifts the table down. Add walks the table one entry
//   per cycle through a shared read port and one compare: a position scan, a merge
//   scan and a shift, and on a full table a smallest-entry scan, an evicting shift,
//   a second position scan and a second shift. A gap query visits each stored range in S_G_END and S_G_NEXT.
// Reset clears the table count and sets max_gaps to 17; no clearing pass.
module received_range_gap_tracker_unit
   import rgt_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_A_POS, S_A_SPAN, S_A_MERGE, S_A_CHK, S_A_PREV,
      S_A_INS, S_A_SMALL, S_MOVE_DN, S_MOVE_UP, S_G_END, S_G_NEXT, S_FIN
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   req_type     req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in, k_ff, k_in, j_ff, j_in, pos_ff, pos_in;
   logic [CW-1:0] d_ff, d_in, small_ff, small_in;
   logic [4:0]  n_ff, n_in, mg_ff, mg_in;
   logic        repos_ff, repos_in;
   logic [32:0] last_end_ff, last_end_in;
   logic [31:0] smin_ff, smin_in;
   logic        pend_v_ff, pend_v_in;
   logic [31:0] pend_off_ff, pend_off_in, pend_len_ff, pend_len_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] start_ff [MAX_ENTRIES];
   logic [31:0] len_ff [MAX_ENTRIES];

   logic          wr_en;
   logic [IW-1:0] wr_idx, rd_idx;
   logic [31:0]   wr_start, wr_len, rd_start, rd_len;
   logic [32:0]   rd_end, new_end, merge_end, src;
   logic [31:0]   gap_end, goff;
   logic [4:0]    limit;
   logic          out_load, out_ready, hit;
   rsp_type       out_data;

   assign rd_start  = start_ff[rd_idx];
   assign rd_len    = len_ff[rd_idx];
   assign rd_end    = {1'b0, rd_start} + {1'b0, rd_len};
   assign new_end   = {1'b0, req_ff.item_offset} + {1'b0, req_ff.item_length};
   assign merge_end = (last_end_ff > new_end) ? last_end_ff : new_end;
   assign limit     = (mg_ff > RESULT_CAP) ? RESULT_CAP : mg_ff;
   assign src       = 33'(k_ff) + 33'(d_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign goff      = (last_end_ff[31:0] > req_ff.query_start) ? last_end_ff[31:0]
                                                                : req_ff.query_start;

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;     req_in = req_ff;
      cnt_in = cnt_ff;       k_in = k_ff;         j_in = j_ff;
      pos_in = pos_ff;       d_in = d_ff;         small_in = small_ff;
      n_in = n_ff;           repos_in = repos_ff; last_end_in = last_end_ff;
      smin_in = smin_ff;     pend_v_in = pend_v_ff;
      pend_off_in = pend_off_ff;                  pend_len_in = pend_len_ff;
      st_in = st_ff;
      mg_in = csr_write_enable ? csr_write_data : mg_ff;
      wr_en = 1'b0;  wr_idx = '0;  rd_idx = '0;
      wr_start = rd_start;  wr_len = rd_len;
      gap_end = '0;  hit = 1'b0;
      out_load = 1'b0;
      out_data.status       = st_ff;
      out_data.gap_valid    = pend_v_ff;
      out_data.gap_offset   = pend_off_ff;
      out_data.gap_length   = pend_len_ff;
      out_data.last         = 1'b1;
      out_data.entry_count  = 5'(cnt_ff);
      out_data.first_valid  = (cnt_ff != '0);
      out_data.first_offset = (cnt_ff != '0) ? start_ff[0] : '0;
      out_data.first_length = (cnt_ff != '0) ? len_ff[0] : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            st_in = STATUS_OK;
            pend_v_in = 1'b0;  pend_off_in = '0;  pend_len_in = '0;
            unique case (mode_type'(req_ff.mode))
               MODE_ADD: begin
                  if (req_ff.item_length == '0 || new_end[32]) begin
                     st_in = STATUS_BAD_ADD;
                     state_in = S_FIN;
                  end else begin
                     k_in = '0;  repos_in = 1'b0;
                     state_in = S_A_POS;
                  end
               end
               MODE_REMOVE: begin
                  if (cnt_ff == '0) begin
                     st_in = STATUS_EMPTY_RM;
                     state_in = S_FIN;
                  end else if (req_ff.item_length >= rd_len) begin
                     k_in = '0;  d_in = CW'(1);  ret_in = S_FIN;
                     state_in = S_MOVE_DN;
                  end else begin
                     wr_en = 1'b1;
                     wr_start = rd_start + req_ff.item_length;
                     wr_len = rd_len - req_ff.item_length;
                     state_in = S_FIN;
                  end
               end
               MODE_GAPS: begin
                  if (req_ff.file_total == '0 ||
                      req_ff.query_start >= req_ff.file_total) begin
                     st_in = STATUS_BAD_QUERY;
                     state_in = S_FIN;
                  end else if (cnt_ff == '0) begin
                     pend_v_in = 1'b1;
                     pend_len_in = req_ff.file_total;
                     state_in = S_FIN;
                  end else begin
                     k_in = '0;  n_in = '0;
                     if (req_ff.query_start < rd_start) begin
                        // leading gap counts even when max_gaps is zero
                        pend_v_in = 1'b1;
                        pend_off_in = req_ff.query_start;
                        pend_len_in = rd_start - req_ff.query_start;
                        n_in = 5'd1;
                     end
                     state_in = S_G_END;
                  end
               end
               MODE_CLEAR: begin
                  cnt_in = '0;
                  state_in = S_FIN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_G_END: begin
            rd_idx = k_ff[IW-1:0];
            last_end_in = rd_end;
            if (!(n_ff < limit && k_ff < cnt_ff)) begin
               state_in = S_FIN;
            end else if (rd_end >= {1'b0, req_ff.file_total}) begin
               state_in = S_FIN;
            end else begin
               state_in = S_G_NEXT;
            end
         end
         S_G_NEXT: begin
            rd_idx = IW'(k_ff + CW'(1));
            gap_end = ((CW+1)'(k_ff) + (CW+1)'(1) == (CW+1)'(cnt_ff)) ?
                      req_ff.file_total : rd_start;
            hit = (req_ff.query_start < gap_end);
            if (!(hit && pend_v_ff && !out_ready)) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     out_load = 1'b1;
                     out_data.last = 1'b0;
                  end
                  pend_v_in = 1'b1;
                  pend_off_in = goff;
                  pend_len_in = gap_end - goff;
                  n_in = n_ff + 5'd1;
               end
               k_in = k_ff + CW'(1);
               state_in = S_G_END;
            end
         end
         S_FIN: begin
            if (out_ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_A_POS: begin
            rd_idx = k_ff[IW-1:0];
            if (k_ff < cnt_ff && rd_start < req_ff.item_offset) begin
               k_in = k_ff + CW'(1);
            end else begin
               pos_in = k_ff;
               if (repos_ff) begin
                  k_in = cnt_ff;
                  state_in = S_MOVE_UP;
               end else begin
                  j_in = k_ff;
                  state_in = S_A_SPAN;
               end
            end
         end
         S_A_SPAN: begin
            rd_idx = j_ff[IW-1:0];
            if (j_ff < cnt_ff && new_end >= {1'b0, rd_start}) begin
               last_end_in = rd_end;
               j_in = j_ff + CW'(1);
            end else if (j_ff != pos_ff) begin
               state_in = S_A_MERGE;
            end else if (pos_ff != '0) begin
               state_in = S_A_PREV;
            end else begin
               state_in = S_A_INS;
            end
         end
         S_A_MERGE: begin
            wr_en = 1'b1;
            wr_idx = pos_ff[IW-1:0];
            wr_start = req_ff.item_offset;
            wr_len = 32'(merge_end - {1'b0, req_ff.item_offset});
            last_end_in = merge_end;
            d_in = j_ff - pos_ff - CW'(1);
            k_in = pos_ff + CW'(1);
            ret_in = S_A_CHK;
            state_in = (j_ff - pos_ff != CW'(1)) ? S_MOVE_DN : S_A_CHK;
         end
         S_A_CHK: begin
            rd_idx = IW'(pos_ff - CW'(1));
            if (pos_ff != '0 && {1'b0, req_ff.item_offset} <= rd_end) begin
               if (rd_end < last_end_ff) begin
                  wr_en = 1'b1;
                  wr_idx = rd_idx;
                  wr_len = 32'(last_end_ff - {1'b0, rd_start});
               end
               k_in = pos_ff;  d_in = CW'(1);  ret_in = S_FIN;
               state_in = S_MOVE_DN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_A_PREV: begin
            rd_idx = IW'(pos_ff - CW'(1));
            if ({1'b0, req_ff.item_offset} <= rd_end) begin
               if (rd_end < new_end) begin
                  wr_en = 1'b1;
                  wr_idx = rd_idx;
                  wr_len = 32'(new_end - {1'b0, rd_start});
               end
               state_in = S_FIN;
            end else begin
               state_in = S_A_INS;
            end
         end
         S_A_INS: begin
            if (cnt_ff < CNT_MAX) begin
               k_in = cnt_ff;
               state_in = S_MOVE_UP;
            end else begin
               smin_in = rd_len;
               small_in = '0;
               k_in = CW'(1);
               state_in = S_A_SMALL;
            end
         end
         S_A_SMALL: begin
            rd_idx = k_ff[IW-1:0];
            if (k_ff < cnt_ff) begin
               if (rd_len < smin_ff) begin
                  smin_in = rd_len;
                  small_in = k_ff;
               end
               k_in = k_ff + CW'(1);
            end else if (smin_ff < req_ff.item_length) begin
               // evict the smallest range, then find the new slot again
               k_in = small_ff;  d_in = CW'(1);  ret_in = S_A_POS;
               repos_in = 1'b1;
               state_in = S_MOVE_DN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MOVE_DN: begin
            rd_idx = src[IW-1:0];
            if (src < 33'(cnt_ff)) begin
               wr_en = 1'b1;
               wr_idx = k_ff[IW-1:0];
               k_in = k_ff + CW'(1);
            end else begin
               cnt_in = cnt_ff - d_ff;
               k_in = '0;
               state_in = ret_ff;
            end
         end
         S_MOVE_UP: begin
            rd_idx = IW'(k_ff - CW'(1));
            wr_en = 1'b1;
            wr_idx = k_ff[IW-1:0];
            if (k_ff > pos_ff) begin
               k_in = k_ff - CW'(1);
            end else begin
               wr_start = req_ff.item_offset;
               wr_len = req_ff.item_length;
               cnt_in = cnt_ff + CW'(1);
               state_in = S_FIN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         mg_ff    <= MAX_GAPS_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mg_ff    <= mg_in;
      end
      ret_ff <= ret_in;          req_ff <= req_in;
      k_ff <= k_in;              j_ff <= j_in;
      pos_ff <= pos_in;          d_ff <= d_in;
      small_ff <= small_in;      n_ff <= n_in;
      repos_ff <= repos_in;      last_end_ff <= last_end_in;
      smin_ff <= smin_in;        pend_v_ff <= pend_v_in;
      pend_off_ff <= pend_off_in;
      pend_len_ff <= pend_len_in;
      st_ff <= st_in;
      if (wr_en) begin
         start_ff[wr_idx] <= wr_start;
         len_ff[wr_idx]   <= wr_len;
      end
   end

   rgt_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/rgt_rsp_reg.sv */
// Response output register with valid/stall handshake.
// Decouples the sequencer from a stalling receiver. Uses rgt_pkg.
module rgt_rsp_reg
   import rgt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign ready     = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* dv/received_range_gap_tracker_unit_tb.sv */
// Self-checking testbench for received_range_gap_tracker_unit.
// Depends on rgt_pkg and the design top; predicts responses with an in-bench range table.
module received_range_gap_tracker_unit_tb;
   import rgt_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_MAX_ENTRIES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   class range_table_scoreboard;
      logic [31:0] starts[TABLE_DEPTH];
      logic [31:0] lengths[TABLE_DEPTH];
      int unsigned count;
      logic [4:0] gap_limit;
      rsp_type pending[$];
      int errors;

      function void clear_table();
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            starts[k] = '0;
            lengths[k] = '0;
         end
         count = 0;
      endfunction

      function void reset_state();
         clear_table();
         gap_limit = MAX_GAPS_RESET;
         pending.delete();
         errors = 0;
      endfunction

      function logic [32:0] end_at(int unsigned k);
         return {1'b0, starts[k]} + {1'b0, lengths[k]};
      endfunction

      function void erase_span(int unsigned from, int unsigned upto);
         int unsigned width;
         if (upto > count) upto = count;
         if (from >= upto) return;
         width = upto - from;
         for (int unsigned k = from; k + width < count; k++) begin
            starts[k] = starts[k + width];
            lengths[k] = lengths[k + width];
         end
         count -= width;
      endfunction

      function int unsigned lower_pos(logic [31:0] off);
         int unsigned k;
         k = 0;
         while (k < count && starts[k] < off) k++;
         return k;
      endfunction

      function void put_at(int unsigned pos, logic [31:0] off, logic [31:0] len);
         if (count >= TABLE_DEPTH || pos > count) return;
         for (int unsigned k = count; k > pos; k--) begin
            starts[k] = starts[k - 1];
            lengths[k] = lengths[k - 1];
         end
         starts[pos] = off;
         lengths[pos] = len;
         count++;
      endfunction

      function void merge_range(logic [31:0] off, logic [31:0] len);
         int unsigned pos, j, smallest;
         logic [32:0] new_end, e, left_end, cur_end;
         pos = lower_pos(off);
         new_end = {1'b0, off} + {1'b0, len};
         j = pos;
         while (j < count && new_end >= {1'b0, starts[j]}) j++;
         if (j != pos) begin
            e = end_at(j - 1);
            if (e < new_end) e = new_end;
            starts[pos] = off;
            lengths[pos] = 32'(e - off);
            erase_span(pos + 1, j);
            if (pos > 0 && {1'b0, starts[pos]} <= end_at(pos - 1)) begin
               left_end = end_at(pos - 1);
               cur_end = end_at(pos);
               if (left_end < cur_end) lengths[pos - 1] = 32'(cur_end - starts[pos - 1]);
               erase_span(pos, pos + 1);
            end
            return;
         end
         if (pos > 0 && {1'b0, off} <= end_at(pos - 1)) begin
            if (end_at(pos - 1) < new_end) lengths[pos - 1] = 32'(new_end - starts[pos - 1]);
            return;
         end
         if (count < TABLE_DEPTH) begin
            put_at(pos, off, len);
         end else begin
            smallest = 0;
            for (int unsigned k = 1; k < count; k++)
               if (lengths[k] < lengths[smallest]) smallest = k;
            // full table: a strictly longer range evicts the shortest one
            if (lengths[smallest] < len) begin
               erase_span(smallest, smallest + 1);
               put_at(lower_pos(off), off, len);
            end
         end
      endfunction

      function void push_rsp(status_type st, logic gv, logic [31:0] go, logic [31:0] gl);
         rsp_type r;
         r = '0;
         r.status = st;
         r.gap_valid = gv;
         r.gap_offset = go;
         r.gap_length = gl;
         r.entry_count = 5'(count);
         r.first_valid = count != 0;
         r.first_offset = count != 0 ? starts[0] : '0;
         r.first_length = count != 0 ? lengths[0] : '0;
         pending.push_back(r);
      endfunction

      function void note_request(req_type q);
         int unsigned made, limit, i;
         logic [31:0] amt, gap_end, goff;
         logic [32:0] gstart;
         made = 0;
         case (mode_type'(q.mode))
            MODE_ADD: begin
               if (q.item_length == 0 ||
                   ({1'b0, q.item_offset} + {1'b0, q.item_length}) > 33'hFFFF_FFFF) begin
                  push_rsp(STATUS_BAD_ADD, 1'b0, '0, '0);
               end else begin
                  merge_range(q.item_offset, q.item_length);
                  push_rsp(STATUS_OK, 1'b0, '0, '0);
               end
               made = 1;
            end
            MODE_REMOVE: begin
               if (count == 0) begin
                  push_rsp(STATUS_EMPTY_RM, 1'b0, '0, '0);
               end else begin
                  amt = q.item_length < lengths[0] ? q.item_length : lengths[0];
                  lengths[0] -= amt;
                  if (lengths[0] == 0) erase_span(0, 1);
                  else starts[0] += amt;
                  push_rsp(STATUS_OK, 1'b0, '0, '0);
               end
               made = 1;
            end
            MODE_GAPS: begin
               if (q.file_total == 0 || q.query_start >= q.file_total) begin
                  push_rsp(STATUS_BAD_QUERY, 1'b0, '0, '0);
                  made = 1;
               end else if (count == 0) begin
                  push_rsp(STATUS_OK, 1'b1, '0, q.file_total);
                  made = 1;
               end else begin
                  limit = gap_limit > RESULT_CAP ? RESULT_CAP : gap_limit;
                  i = 0;
                  if (q.query_start < starts[0]) begin
                     push_rsp(STATUS_OK, 1'b1, q.query_start, starts[0] - q.query_start);
                     made++;
                  end
                  while (made < limit && i < count) begin
                     gap_end = (i + 1 == count) ? q.file_total : starts[i + 1];
                     gstart = end_at(i);
                     if (gstart >= {1'b0, q.file_total}) break;
                     goff = gstart[31:0] > q.query_start ? gstart[31:0] : q.query_start;
                     if (q.query_start < gap_end) begin
                        push_rsp(STATUS_OK, 1'b1, goff, gap_end - goff);
                        made++;
                     end
                     i++;
                  end
                  if (made == 0) begin
                     push_rsp(STATUS_OK, 1'b0, '0, '0);
                     made = 1;
                  end
               end
            end
            default: begin
               clear_table();
               push_rsp(STATUS_OK, 1'b0, '0, '0);
               made = 1;
            end
         endcase
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      task check_rsp(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with none expected", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) report_mismatch("status", got.status, want.status);
         if (got.gap_valid !== want.gap_valid)
            report_mismatch("gap_valid", got.gap_valid, want.gap_valid);
         if (got.gap_offset !== want.gap_offset)
            report_mismatch("gap_offset", got.gap_offset, want.gap_offset);
         if (got.gap_length !== want.gap_length)
            report_mismatch("gap_length", got.gap_length, want.gap_length);
         if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
         if (got.first_valid !== want.first_valid)
            report_mismatch("first_valid", got.first_valid, want.first_valid);
         if (got.first_offset !== want.first_offset)
            report_mismatch("first_offset", got.first_offset, want.first_offset);
         if (got.first_length !== want.first_length)
            report_mismatch("first_length", got.first_length, want.first_length);
      endtask

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %h expected %h", what, got, want);
         errors++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;
   logic hold_off_go = 1'b0;

   range_table_scoreboard tracker_model;
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 66;
   int unsigned hold_off_cycles = 0;
   int unsigned cycle_count = 0;

   received_range_gap_tracker_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver side: check accepted responses and pick the next stall value
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker_model.check_rsp(rsp_data);
         if (hold_off_go) begin
            rsp_stall <= 1'b1;
            hold_off_cycles <= HOLD_OFF_CYCLES;
         end else if (hold_off_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
         end else begin
            rsp_stall <= $urandom_range(99) < recv_idle_pct;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("received_range_gap_tracker_unit verification failed");
         $finish;
      end
   end

   // valid stays high after acceptance until the next request or an idle cycle
   task automatic send_request(req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker_model.note_request(q);
   endtask

   task automatic send_op(mode_type m, logic [31:0] off, logic [31:0] len,
                          logic [31:0] total, logic [31:0] start);
      req_type q;
      q.mode = m;
      q.item_offset = off;
      q.item_length = len;
      q.file_total = total;
      q.query_start = start;
      send_request(q);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker_model.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_gap_limit(logic [4:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker_model.gap_limit = value;
   endtask

   // mostly small offsets within a window so ranges collide and merge
   task automatic send_random(int unsigned window);
      req_type q;
      int unsigned pick;
      pick = $urandom_range(99);
      q.item_offset = $urandom_range(window);
      q.item_length = $urandom_range(1, window / 8 + 1);
      q.file_total = $urandom_range(1, window + 64);
      q.query_start = $urandom_range(window);
      if (pick < 50) q.mode = MODE_ADD;
      else if (pick < 65) q.mode = MODE_REMOVE;
      else if (pick < 90) q.mode = MODE_GAPS;
      else if (pick < 93) q.mode = MODE_CLEAR;
      else begin
         // full-width noise
         q = {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
         if (q.mode == MODE_CLEAR) q.mode = MODE_GAPS;
      end
      send_request(q);
   endtask

   initial begin
      tracker_model = new();
      tracker_model.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: error cases, extremes, merges, full-table eviction
      send_op(MODE_REMOVE, 0, 5, 0, 0);
      send_op(MODE_GAPS, 0, 0, 0, 0);
      send_op(MODE_GAPS, 0, 0, 100, 100);
      send_op(MODE_GAPS, 0, 0, 100, 40);
      send_op(MODE_ADD, 5, 0, 0, 0);
      send_op(MODE_ADD, 32'hFFFF_FFFF, 1, 0, 0);
      send_op(MODE_ADD, 32'hFFFF_FFFE, 1, 0, 0);
      send_op(MODE_ADD, 0, 32'hFFFF_FFFF, 0, 0);
      send_op(MODE_CLEAR, 0, 0, 0, 0);
      send_op(MODE_ADD, 100, 10, 0, 0);
      send_op(MODE_ADD, 110, 5, 0, 0);
      send_op(MODE_ADD, 90, 10, 0, 0);
      send_op(MODE_ADD, 200, 20, 0, 0);
      send_op(MODE_ADD, 95, 120, 0, 0);
      send_op(MODE_REMOVE, 0, 0, 0, 0);
      send_op(MODE_REMOVE, 0, 7, 0, 0);
      for (int k = 0; k < 17; k++) send_op(MODE_ADD, 1000 + k * 10, 2 + k % 3, 0, 0);
      send_op(MODE_ADD, 5000, 1, 0, 0);
      send_op(MODE_GAPS, 0, 0, 300, 0);
      send_op(MODE_GAPS, 0, 0, 32'hFFFF_FFFF, 1500);
      send_op(MODE_REMOVE, 0, 32'hFFFF_FFFF, 0, 0);
      write_gap_limit(5'd0);
      send_op(MODE_GAPS, 0, 0, 2000, 0);
      send_op(MODE_GAPS, 0, 0, 2000, 1200);
      write_gap_limit(5'd1);
      send_op(MODE_GAPS, 0, 0, 2000, 0);
      write_gap_limit(5'd31);
      send_op(MODE_GAPS, 0, 0, 2000, 0);

      // long receiver hold-off while the sender keeps going
      wait_drained();
      hold_off_go <= 1'b1;
      @(posedge clock);
      hold_off_go <= 1'b0;
      for (int n = 0; n < 20; n++) send_random(4000);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 66;
            recv_idle_pct = 13;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_gap_limit(phase == 0 ? 5'd17 : phase == 1 ? 5'd3 : 5'($urandom_range(1, 31)));
         for (int n = 0; n < 70; n++) send_random(phase == 1 ? 300 : 3000);
      end

      wait_drained();
      if (tracker_model.errors == 0)
         $display("received_range_gap_tracker_unit verification clean");
      else
         $display("received_range_gap_tracker_unit verification failed");
      $finish;
   end
endmodule

/* filelist.f */
design/rgt_pkg.sv
design/rgt_rsp_reg.sv
design/received_range_gap_tracker_unit.sv
dv/received_range_gap_tracker_unit_tb.sv
